// ----- hdl/pwiz_pkg.sv -----
// ============================================================================
// pwiz_pkg
// Shared types and constants of the integral-zone PID controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pwiz_pkg;

  localparam int DEF_POS_WIDTH = 24;

  localparam int GAIN_W    = 16;
  localparam int ZONE_W    = 24;
  localparam int IMAX_W    = 16;
  localparam int LIM_W     = 7;
  localparam int BAND_W    = 8;
  localparam int CNT_W     = 8;
  localparam int INTEG_W   = 18;
  localparam int DRIVE_W   = 8;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  localparam logic [LIM_W-1:0]  RST_OUTPUT_LIMIT  = 7'd127;
  localparam logic [BAND_W-1:0] RST_SETTLE_BAND   = 8'd7;
  localparam logic [CNT_W-1:0]  RST_SETTLE_NEEDED = 8'd20;
  localparam logic [CNT_W-1:0]  CNT_MAX           = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P        = 3'd0,
    REG_GAIN_I        = 3'd1,
    REG_GAIN_D        = 3'd2,
    REG_INTEGRAL_ZONE = 3'd3,
    REG_MAX_INTEGRAL  = 3'd4,
    REG_OUTPUT_LIMIT  = 3'd5,
    REG_SETTLE_BAND   = 3'd6,
    REG_SETTLE_NEEDED = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ZONE_W-1:0] integral_zone;
    logic [IMAX_W-1:0] max_integral;
    logic [BAND_W-1:0] settle_band;
    logic [CNT_W-1:0]  settle_needed;
  } state_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/pid_with_integral_zone.sv -----
// ============================================================================
// pid_with_integral_zone
// Position PID controller with an integral zone and a settle detector.
// ============================================================================
// Each input item carries a setpoint, a measured position and a restart flag;
// each produces exactly one result item with the saturated drive, the position
// error and the settled flag. Items move on a valid/stall handshake on both
// sides. Registers are written through the cfg channel, which is always ready;
// writes belong in idle periods.
// The datapath is four register stages: input, state update, the three gain
// products, and the result register. An accepted item passes through these
// stages in order and is then shown on the outputs with out_valid high; one
// item is accepted per cycle while in_stall is low.
// The integral, previous error and settle count change when an item enters
// the state stage, so items are handled strictly in order.
// When the receiver stalls, the result stays on the outputs and the stages
// behind it keep filling until each holds an item; only then is in_stall
// raised. Reset empties the pipeline, clears the controller state and loads
// the register defaults.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pid_with_integral_zone #(
  parameter int POS_WIDTH = pwiz_pkg::DEF_POS_WIDTH
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire signed [POS_WIDTH-1:0]            in_setpoint,
  input  wire signed [POS_WIDTH-1:0]            in_measured,
  input  wire                                   in_restart,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [pwiz_pkg::DRIVE_W-1:0]   out_drive,
  output logic signed [POS_WIDTH:0]             out_position_error,
  output logic                                  out_settled,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [pwiz_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [pwiz_pkg::CFG_DAT_W-1:0]         cfg_data
);

  localparam int EW  = POS_WIDTH + 1;
  localparam int DW  = POS_WIDTH + 2;
  localparam int IW  = pwiz_pkg::INTEG_W;
  localparam int GW  = pwiz_pkg::GAIN_W + 1;
  localparam int PPW = GW + EW;
  localparam int PIW = GW + IW;
  localparam int PDW = GW + DW;
  localparam int AW  = POS_WIDTH + 21;

  // Configuration registers.
  logic [pwiz_pkg::GAIN_W-1:0]   gain_p_r, gain_i_r, gain_d_r;
  logic [pwiz_pkg::ZONE_W-1:0]   integral_zone_r;
  logic [pwiz_pkg::IMAX_W-1:0]   max_integral_r;
  logic [pwiz_pkg::LIM_W-1:0]    output_limit_r;
  logic [pwiz_pkg::BAND_W-1:0]   settle_band_r;
  logic [pwiz_pkg::CNT_W-1:0]    settle_needed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r        <= '0;
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      integral_zone_r <= '0;
      max_integral_r  <= '0;
      output_limit_r  <= pwiz_pkg::RST_OUTPUT_LIMIT;
      settle_band_r   <= pwiz_pkg::RST_SETTLE_BAND;
      settle_needed_r <= pwiz_pkg::RST_SETTLE_NEEDED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pwiz_pkg::reg_idx_t'(cfg_index))
        pwiz_pkg::REG_GAIN_P:        gain_p_r        <= cfg_data[15:0];
        pwiz_pkg::REG_GAIN_I:        gain_i_r        <= cfg_data[15:0];
        pwiz_pkg::REG_GAIN_D:        gain_d_r        <= cfg_data[15:0];
        pwiz_pkg::REG_INTEGRAL_ZONE: integral_zone_r <= cfg_data[23:0];
        pwiz_pkg::REG_MAX_INTEGRAL:  max_integral_r  <= cfg_data[15:0];
        pwiz_pkg::REG_OUTPUT_LIMIT:  output_limit_r  <= cfg_data[6:0];
        pwiz_pkg::REG_SETTLE_BAND:   settle_band_r   <= cfg_data[7:0];
        pwiz_pkg::REG_SETTLE_NEEDED: settle_needed_r <= cfg_data[7:0];
      endcase
    end
  end

  // Pipeline control.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Stage 1: input register.
  logic signed [POS_WIDTH-1:0] sp1_r, ms1_r;
  logic                        rs1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      sp1_r <= in_setpoint;
      ms1_r <= in_measured;
      rs1_r <= in_restart;
    end
  end

  // Stage 2: controller state update.
  pwiz_pkg::state_cfg_t   st_cfg;
  logic signed [EW-1:0]   st_err;
  logic signed [DW-1:0]   st_deriv;
  logic signed [IW-1:0]   st_integ;
  logic                   st_settled;

  assign st_cfg.integral_zone = integral_zone_r;
  assign st_cfg.max_integral  = max_integral_r;
  assign st_cfg.settle_band   = settle_band_r;
  assign st_cfg.settle_needed = settle_needed_r;

  pwiz_state #(
    .POS_WIDTH (POS_WIDTH)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (v1_r && rdy2),
    .setpoint    (sp1_r),
    .measured    (ms1_r),
    .restart     (rs1_r),
    .cfg         (st_cfg),
    .err         (st_err),
    .deriv       (st_deriv),
    .integ_new   (st_integ),
    .settled_new (st_settled)
  );

  logic signed [EW-1:0] err2_r;
  logic signed [DW-1:0] deriv2_r;
  logic signed [IW-1:0] integ2_r;
  logic                 settled2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      err2_r     <= st_err;
      deriv2_r   <= st_deriv;
      integ2_r   <= st_integ;
      settled2_r <= st_settled;
    end
  end

  // Stage 3: gain products.
  logic signed [PPW-1:0] prod_p, prod_p3_r;
  logic signed [PIW-1:0] prod_i, prod_i3_r;
  logic signed [PDW-1:0] prod_d, prod_d3_r;
  logic signed [EW-1:0]  err3_r;
  logic                  settled3_r;

  assign prod_p = $signed({1'b0, gain_p_r}) * err2_r;
  assign prod_i = $signed({1'b0, gain_i_r}) * integ2_r;
  assign prod_d = $signed({1'b0, gain_d_r}) * deriv2_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      prod_p3_r  <= prod_p;
      prod_i3_r  <= prod_i;
      prod_d3_r  <= prod_d;
      err3_r     <= err2_r;
      settled3_r <= settled2_r;
    end
  end

  // Stage 4: sum, scale and saturate into the result register.
  logic signed [AW-1:0]                 acc;
  logic signed [AW-1:0]                 acc_sh;
  logic signed [AW-1:0]                 lim;
  logic signed [pwiz_pkg::DRIVE_W-1:0]  drive_nxt;
  logic signed [pwiz_pkg::DRIVE_W-1:0]  drive_r;
  logic signed [EW-1:0]                 err4_r;
  logic                                 settled4_r;

  assign acc    = AW'(prod_p3_r) + AW'(prod_i3_r) + AW'(prod_d3_r);
  assign acc_sh = acc >>> pwiz_pkg::FRAC_BITS;
  assign lim    = AW'($signed({1'b0, output_limit_r}));

  always_comb begin
    if (acc_sh > lim) begin
      drive_nxt = pwiz_pkg::DRIVE_W'(lim);
    end else if (acc_sh < -lim) begin
      drive_nxt = pwiz_pkg::DRIVE_W'(-lim);
    end else begin
      drive_nxt = pwiz_pkg::DRIVE_W'(acc_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      drive_r    <= drive_nxt;
      err4_r     <= err3_r;
      settled4_r <= settled3_r;
    end
  end

  assign out_valid          = v4_r;
  assign out_drive          = drive_r;
  assign out_position_error = err4_r;
  assign out_settled        = settled4_r;

  // Assertions.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drive != $signed(8'h80)))
    else $error("drive left the symmetric range");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with an empty input stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// ----- hdl/pwiz_state.sv -----
// ============================================================================
// pwiz_state
// Error, integral, previous error and settle counter of the controller.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pwiz_state #(
  parameter int POS_WIDTH = pwiz_pkg::DEF_POS_WIDTH
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   upd,
  input  wire signed [POS_WIDTH-1:0]            setpoint,
  input  wire signed [POS_WIDTH-1:0]            measured,
  input  wire                                   restart,
  input  pwiz_pkg::state_cfg_t                  cfg,
  output logic signed [POS_WIDTH:0]             err,
  output logic signed [POS_WIDTH+1:0]           deriv,
  output logic signed [pwiz_pkg::INTEG_W-1:0]   integ_new,
  output logic                                  settled_new
);

  localparam int EW = POS_WIDTH + 1;
  localparam int DW = POS_WIDTH + 2;
  localparam int IW = pwiz_pkg::INTEG_W;
  localparam int SW = ((EW > IW) ? EW : IW) + 1;
  localparam int CW = (EW > pwiz_pkg::ZONE_W) ? EW : pwiz_pkg::ZONE_W;

  logic signed [IW-1:0]          integ_r;
  logic signed [EW-1:0]          last_r;
  logic [pwiz_pkg::CNT_W-1:0]    cnt_r;

  logic [EW-1:0]                 mag;
  logic                          in_zone;
  logic                          in_band;
  logic signed [IW-1:0]          integ_base;
  logic signed [EW-1:0]          last_base;
  logic [pwiz_pkg::CNT_W-1:0]    cnt_base;
  logic [pwiz_pkg::CNT_W-1:0]    cnt_nxt;
  logic signed [SW-1:0]          isum;
  logic signed [SW-1:0]          imax;

  assign err  = EW'(setpoint) - EW'(measured);
  assign mag  = err[EW-1] ? EW'(-err) : EW'(err);

  assign in_zone = CW'(mag) < CW'(cfg.integral_zone);
  assign in_band = mag <= EW'(cfg.settle_band);

  assign integ_base = restart ? '0 : integ_r;
  assign last_base  = restart ? '0 : last_r;
  assign cnt_base   = restart ? '0 : cnt_r;

  assign isum = SW'(integ_base) + SW'(err);
  assign imax = SW'($signed({1'b0, cfg.max_integral}));

  always_comb begin
    if (!in_zone) begin
      integ_new = '0;
    end else if (isum > imax) begin
      integ_new = IW'(imax);
    end else if (isum < -imax) begin
      integ_new = IW'(-imax);
    end else begin
      integ_new = IW'(isum);
    end
  end

  assign deriv = DW'(err) - DW'(last_base);

  assign cnt_nxt     = (in_band && (cnt_base != pwiz_pkg::CNT_MAX)) ? cnt_base + 1'b1
                                                                    : cnt_base;
  assign settled_new = cnt_nxt >= cfg.settle_needed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      last_r  <= '0;
      cnt_r   <= '0;
    end else if (upd) begin
      integ_r <= integ_new;
      last_r  <= err;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/pid_with_integral_zone_tb.sv -----
// ============================================================================
// pid_with_integral_zone_tb
// Self-checking testbench for the integral-zone PID controller.
// ============================================================================
// A behavioral model of the controller predicts drive, position error and the
// settled flag for every item the block accepts. A checker compares each
// result against the oldest prediction. Directed tests cover reset defaults,
// full-scale positions and gains, and each corner of the controller. These
// include a zero drive limit, a zero integral zone, a zero settle count,
// restart, and register writes wider than the register. Random phases then
// vary the settings and send approach sequences mixed with noise. The sender
// idles in bursts, and the receiver stalls in changing patterns. One long
// receiver hold-off backs up the pipeline.
// ============================================================================
`timescale 1ns / 1ps

module pid_with_integral_zone_tb;

  localparam int PW = pwiz_pkg::DEF_POS_WIDTH;
  localparam int DRIVE_W = pwiz_pkg::DRIVE_W;
  localparam int CFG_IDX_W = pwiz_pkg::CFG_IDX_W;
  localparam int CFG_DAT_W = pwiz_pkg::CFG_DAT_W;
  localparam int GAIN_W = pwiz_pkg::GAIN_W;
  localparam int ZONE_W = pwiz_pkg::ZONE_W;
  localparam int IMAX_W = pwiz_pkg::IMAX_W;
  localparam int LIM_W = pwiz_pkg::LIM_W;
  localparam int BAND_W = pwiz_pkg::BAND_W;
  localparam int CNT_W = pwiz_pkg::CNT_W;
  localparam int FRAC_BITS = pwiz_pkg::FRAC_BITS;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic signed [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [PW:0]        perr;
    logic                      settled;
  } ctrl_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PW-1:0] in_setpoint = '0;
  logic signed [PW-1:0] in_measured = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DRIVE_W-1:0] out_drive;
  logic signed [PW:0] out_position_error;
  logic out_settled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  logic [GAIN_W-1:0] kp_r, ki_r, kd_r;
  logic [ZONE_W-1:0] zone_r;
  logic [IMAX_W-1:0] imax_r;
  logic [LIM_W-1:0]  lim_r;
  logic [BAND_W-1:0] band_r;
  logic [CNT_W-1:0]  needed_r;
  longint integ_acc, prev_err;
  int on_target_cnt;

  ctrl_out_t predicted[$];
  int fail_count = 0;
  int report_count = 0;
  int cycle_count = 0;
  bit sender_idle = 1'b0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_phase = 0;

  pid_with_integral_zone u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_setpoint(in_setpoint), .in_measured(in_measured), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_drive(out_drive), .out_position_error(out_position_error),
    .out_settled(out_settled),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void predictor_reset();
    kp_r = '0;
    ki_r = '0;
    kd_r = '0;
    zone_r = '0;
    imax_r = '0;
    lim_r = pwiz_pkg::RST_OUTPUT_LIMIT;
    band_r = pwiz_pkg::RST_SETTLE_BAND;
    needed_r = pwiz_pkg::RST_SETTLE_NEEDED;
    integ_acc = 0;
    prev_err = 0;
    on_target_cnt = 0;
  endfunction

  function automatic ctrl_out_t pid_step(input logic signed [PW-1:0] sp,
                                         input logic signed [PW-1:0] ms,
                                         input logic rs);
    ctrl_out_t r;
    longint err, mag, acc, drv, lim, imax;
    if (rs) begin
      integ_acc = 0;
      prev_err = 0;
      on_target_cnt = 0;
    end
    err = longint'(sp) - longint'(ms);
    mag = (err < 0) ? -err : err;
    if (mag < longint'(zone_r)) begin
      integ_acc += err;
    end else begin
      integ_acc = 0;
    end
    imax = longint'(imax_r);
    if (integ_acc > imax) begin
      integ_acc = imax;
    end else if (integ_acc < -imax) begin
      integ_acc = -imax;
    end
    acc = longint'(kp_r) * err + longint'(ki_r) * integ_acc
        + longint'(kd_r) * (err - prev_err);
    drv = acc >>> FRAC_BITS;
    lim = longint'(lim_r);
    if (drv > lim) begin
      drv = lim;
    end else if (drv < -lim) begin
      drv = -lim;
    end
    prev_err = err;
    if (mag <= longint'(band_r) && on_target_cnt < 255) begin
      on_target_cnt++;
    end
    r.drive = drv[DRIVE_W-1:0];
    r.perr = err[PW:0];
    r.settled = (on_target_cnt >= int'(needed_r));
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint exp_v, input longint act_v);
    fail_count++;
    if (report_count < 100) begin
      report_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    ctrl_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted.size() == 0) begin
        report_mismatch("unexpected item", 0, longint'(out_position_error));
      end else begin
        e = predicted.pop_front();
        if (out_drive !== e.drive)
          report_mismatch("drive", longint'(e.drive), longint'(out_drive));
        if (out_position_error !== e.perr)
          report_mismatch("position_error", longint'(e.perr), longint'(out_position_error));
        if (out_settled !== e.settled)
          report_mismatch("settled", longint'(e.settled), longint'(out_settled));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase++;
      if (hold_req && hold_left == 0) begin
        hold_left = 90;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (stall_phase % 4 == 3);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_sample(input logic signed [PW-1:0] sp, input logic signed [PW-1:0] ms,
                             input logic rs);
    in_valid <= 1'b1;
    in_setpoint <= sp;
    in_measured <= ms;
    in_restart <= rs;
    do @(posedge clk); while (in_stall);
    predicted.push_back(pid_step(sp, ms, rs));
    if (sender_idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input pwiz_pkg::reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pwiz_pkg::REG_GAIN_P:        kp_r = data[GAIN_W-1:0];
      pwiz_pkg::REG_GAIN_I:        ki_r = data[GAIN_W-1:0];
      pwiz_pkg::REG_GAIN_D:        kd_r = data[GAIN_W-1:0];
      pwiz_pkg::REG_INTEGRAL_ZONE: zone_r = data[ZONE_W-1:0];
      pwiz_pkg::REG_MAX_INTEGRAL:  imax_r = data[IMAX_W-1:0];
      pwiz_pkg::REG_OUTPUT_LIMIT:  lim_r = data[LIM_W-1:0];
      pwiz_pkg::REG_SETTLE_BAND:   band_r = data[BAND_W-1:0];
      default:                     needed_r = data[CNT_W-1:0];
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DAT_W-1:0] kp, input logic [CFG_DAT_W-1:0] ki,
                           input logic [CFG_DAT_W-1:0] kd, input logic [CFG_DAT_W-1:0] zone,
                           input logic [CFG_DAT_W-1:0] imax, input logic [CFG_DAT_W-1:0] lim,
                           input logic [CFG_DAT_W-1:0] band, input logic [CFG_DAT_W-1:0] need);
    drain_results();
    write_reg(pwiz_pkg::REG_GAIN_P, kp);
    write_reg(pwiz_pkg::REG_GAIN_I, ki);
    write_reg(pwiz_pkg::REG_GAIN_D, kd);
    write_reg(pwiz_pkg::REG_INTEGRAL_ZONE, zone);
    write_reg(pwiz_pkg::REG_MAX_INTEGRAL, imax);
    write_reg(pwiz_pkg::REG_OUTPUT_LIMIT, lim);
    write_reg(pwiz_pkg::REG_SETTLE_BAND, band);
    write_reg(pwiz_pkg::REG_SETTLE_NEEDED, need);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DAT_W-1:0] rand_word(input pwiz_pkg::reg_idx_t idx);
    logic [CFG_DAT_W-1:0] w;
    int unsigned wid, v, mask;
    w = CFG_DAT_W'($urandom());
    case (idx)
      pwiz_pkg::REG_GAIN_P, pwiz_pkg::REG_GAIN_I, pwiz_pkg::REG_GAIN_D: begin
        wid = GAIN_W;
        v = $urandom_range(0, 700);
      end
      pwiz_pkg::REG_INTEGRAL_ZONE: begin
        wid = ZONE_W;
        v = $urandom_range(0, 4000);
      end
      pwiz_pkg::REG_MAX_INTEGRAL: begin
        wid = IMAX_W;
        v = $urandom_range(0, 65535);
      end
      pwiz_pkg::REG_OUTPUT_LIMIT: begin
        wid = LIM_W;
        v = $urandom_range(0, 127);
      end
      pwiz_pkg::REG_SETTLE_BAND: begin
        wid = BAND_W;
        v = $urandom_range(0, 40);
      end
      default: begin
        wid = CNT_W;
        v = $urandom_range(0, 40);
      end
    endcase
    mask = (32'd1 << wid) - 1;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = mask;
      2: v = $urandom() & mask;
      default: ;
    endcase
    return CFG_DAT_W'((w & ~mask) | (v & mask));
  endfunction

  function automatic logic signed [PW-1:0] edge_pos();
    case ($urandom_range(0, 4))
      0: return POS_MIN;
      1: return POS_MAX;
      2: return '0;
      3: return '1;
      default: return PW'(1);
    endcase
  endfunction

  task automatic send_random_sample();
    logic signed [PW-1:0] sp, ms;
    int k, d;
    k = $urandom_range(0, 99);
    ms = PW'($urandom());
    if (k < 35) begin
      d = $urandom_range(0, 600);
      sp = ms + PW'(d - 300);
    end else if (k < 55) begin
      d = $urandom_range(0, 24);
      sp = ms + PW'(d - 12);
    end else if (k < 85) begin
      sp = PW'($urandom());
    end else begin
      sp = edge_pos();
      ms = edge_pos();
    end
    send_sample(sp, ms, $urandom_range(0, 24) == 0);
  endtask

  task automatic send_approach(input int n);
    logic signed [PW-1:0] sp;
    int err;
    sp = PW'($urandom());
    err = $urandom_range(1, 200000);
    if ($urandom_range(0, 1) == 1) err = -err;
    for (int i = 0; i < n; i++) begin
      send_sample(sp, sp - PW'(err), i == 0);
      err = (err * 3) / 4 + $urandom_range(0, 4) - 2;
    end
  endtask

  task automatic test_defaults();
    send_sample('0, '0, 1'b0);
    send_sample(POS_MAX, POS_MIN, 1'b0);
    send_sample(POS_MIN, POS_MAX, 1'b0);
    send_sample(PW'(5), '0, 1'b0);
  endtask

  task automatic test_full_scale();
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              24'hFFFFFF, 24'hFFFFFF, 24'h000001);
    send_sample(POS_MAX, POS_MIN, 1'b0);
    send_sample(POS_MIN, POS_MAX, 1'b0);
    send_sample(PW'(100), '0, 1'b0);
    send_sample('0, PW'(100), 1'b0);
    send_sample('1, '0, 1'b1);
  endtask

  task automatic test_zero_limit();
    configure(24'h000200, 24'h000100, 24'h000100, 24'h001000, 24'h000400,
              24'hFFFF80, 24'h000007, 24'h000002);
    send_sample(PW'(3000), '0, 1'b0);
    send_sample('0, PW'(3000), 1'b0);
  endtask

  task automatic test_zero_zone();
    configure(24'h000000, 24'h00FFFF, 24'h000000, 24'h000000, 24'h00FFFF,
              24'h00007F, 24'h000007, 24'h000014);
    send_sample(PW'(2), '0, 1'b0);
    send_sample(PW'(2), '0, 1'b0);
  endtask

  task automatic test_zero_settle_needed();
    configure(24'h000100, 24'h000000, 24'h000000, 24'h000010, 24'h000010,
              24'h00007F, 24'hFFFF00, 24'hABCD00);
    send_sample(POS_MAX, '0, 1'b0);
    send_sample('0, '0, 1'b1);
  endtask

  task automatic test_restart();
    configure(24'h000080, 24'h000040, 24'h000300, 24'h000100, 24'h000200,
              24'h00007F, 24'h000040, 24'h000002);
    send_sample(PW'(50), '0, 1'b0);
    send_sample(PW'(50), '0, 1'b0);
    send_sample(PW'(50), '0, 1'b1);
    send_sample(PW'(49), '0, 1'b0);
  endtask

  task automatic test_settle_saturation();
    int d;
    configure(24'h000020, 24'h000010, 24'h000040, 24'h000100, 24'h000800,
              24'h00007F, 24'hFF00FF, 24'h0000FF);
    sender_idle = 1'b1;
    send_sample('0, '0, 1'b1);
    for (int i = 0; i < 280; i++) begin
      d = $urandom_range(0, 40);
      send_sample(PW'($urandom_range(0, 200)), PW'(d - 20), 1'b0);
    end
  endtask

  task automatic test_random_phases();
    int n, len;
    for (int ph = 0; ph < 5; ph++) begin
      configure(rand_word(pwiz_pkg::REG_GAIN_P), rand_word(pwiz_pkg::REG_GAIN_I),
                rand_word(pwiz_pkg::REG_GAIN_D), rand_word(pwiz_pkg::REG_INTEGRAL_ZONE),
                rand_word(pwiz_pkg::REG_MAX_INTEGRAL), rand_word(pwiz_pkg::REG_OUTPUT_LIMIT),
                rand_word(pwiz_pkg::REG_SETTLE_BAND), rand_word(pwiz_pkg::REG_SETTLE_NEEDED));
      sender_idle = (ph % 3 != 0);
      n = 0;
      while (n < 90) begin
        if ($urandom_range(0, 9) < 6) begin
          len = $urandom_range(10, 40);
          send_approach(len);
          n += len;
        end else begin
          send_random_sample();
          n++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    configure(rand_word(pwiz_pkg::REG_GAIN_P), rand_word(pwiz_pkg::REG_GAIN_I),
              rand_word(pwiz_pkg::REG_GAIN_D), rand_word(pwiz_pkg::REG_INTEGRAL_ZONE),
              rand_word(pwiz_pkg::REG_MAX_INTEGRAL), rand_word(pwiz_pkg::REG_OUTPUT_LIMIT),
              rand_word(pwiz_pkg::REG_SETTLE_BAND), rand_word(pwiz_pkg::REG_SETTLE_NEEDED));
    sender_idle = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_random_sample();
    end
  endtask

  initial begin
    predictor_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_full_scale();
    test_zero_limit();
    test_zero_zone();
    test_zero_settle_needed();
    test_restart();
    test_settle_saturation();
    test_random_phases();
    test_backpressure();
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pwiz_pkg.sv
hdl/pwiz_state.sv
hdl/pid_with_integral_zone.sv
tb/sv/pid_with_integral_zone_tb.sv
